### rtl/core/segment_hyperplane_intersection_assert.svh
// Assertion macros shared by the RTL.
`ifndef SEGMENT_HYPERPLANE_INTERSECTION_ASSERT_SVH
`define SEGMENT_HYPERPLANE_INTERSECTION_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SHI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SHI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/shi_pkg.sv
package shi_pkg;

  localparam int COORD_W     = 16;  // Q8.8 coordinate
  localparam int DIR_W       = 17;  // b - a, one bit wider
  localparam int TOL_W       = 16;
  localparam int PROD_W      = COORD_W + DIR_W;
  localparam int SUM_W       = 40;  // Q24.16 accumulators
  localparam int FRAC_W      = 16;  // alpha fraction bits
  localparam int ALPHA_W     = FRAC_W + 1;
  localparam int MAX_DIM_DEF = 16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_MAG,
    S_TEST,
    S_DIV,
    S_EMIT,
    S_DRAIN
  } shi_state_t;

  // tag that rides along the read / scale pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } shi_tag_t;

endpackage

### rtl/core/shi_ram.sv
module shi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/shi_div.sv
module shi_div import shi_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [SUM_W-1:0]   num,
  input  logic [SUM_W-1:0]   den,
  output logic               done,
  output logic [ALPHA_W-1:0] quot
);

  // restoring division, one quotient bit per cycle, num <= den assumed
  localparam int STEP_W = $clog2(ALPHA_W);

  logic              run_r, run_nxt;
  logic              first_r, first_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SUM_W-1:0]  rem_r, rem_nxt;
  logic [SUM_W-1:0]  den_r, den_nxt;
  logic [ALPHA_W-1:0] q_r, q_nxt;
  logic [SUM_W:0]    trial;
  logic [SUM_W:0]    diff;
  logic              ge;

  assign trial = first_r ? {1'b0, rem_r} : {rem_r, 1'b0};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};
  assign done  = run_r && (step_r == '0);
  assign quot  = q_r;

  always_comb begin
    run_nxt   = run_r;
    first_nxt = first_r;
    step_nxt  = step_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    q_nxt     = q_r;
    if (start) begin
      run_nxt   = 1'b1;
      first_nxt = 1'b1;
      step_nxt  = STEP_W'(ALPHA_W - 1);
      rem_nxt   = num;
      den_nxt   = den;
      q_nxt     = '0;
    end else if (run_r) begin
      first_nxt = 1'b0;
      rem_nxt   = ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      q_nxt     = {q_r[ALPHA_W-2:0], ge};
      step_nxt  = step_r - STEP_W'(1);
      if (step_r == '0) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
    end
    first_r <= first_nxt;
    step_r  <= step_nxt;
    rem_r   <= rem_nxt;
    den_r   <= den_nxt;
    q_r     <= q_nxt;
  end

endmodule

### rtl/core/shi_scale.sv
module shi_scale import shi_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [ALPHA_W-1:0]        alpha_i,
  input  shi_tag_t                  tag_i,
  input  logic signed [COORD_W-1:0] start_i,
  input  logic signed [DIR_W-1:0]   dir_i,
  output shi_tag_t                  tag_o,
  output logic signed [COORD_W-1:0] coord_o
);

  localparam int SP_W  = ALPHA_W + DIR_W;
  localparam int M_W   = SP_W - FRAC_W;
  localparam int OFF_W = M_W + 1;
  localparam logic [SP_W-1:0] HALF = SP_W'(1) << (FRAC_W - 1);

  logic [DIR_W-1:0]          dir_mag;
  logic [SP_W-1:0]           prod;
  logic [SP_W-1:0]           prod_r;
  logic                      neg_r;
  logic signed [COORD_W-1:0] start_r;
  shi_tag_t                  tag_r;
  logic [SP_W-1:0]           rnd;
  logic signed [OFF_W-1:0]   mag_s;
  logic signed [OFF_W-1:0]   off;
  logic signed [OFF_W-1:0]   sum;

  // stage A: |d| * alpha
  assign dir_mag = dir_i[DIR_W-1] ? DIR_W'(-dir_i) : DIR_W'(dir_i);
  assign prod    = SP_W'(alpha_i) * SP_W'(dir_mag);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_i;
    end
    prod_r  <= prod;
    neg_r   <= dir_i[DIR_W-1];
    start_r <= start_i;
  end

  // stage B: round half away from zero, reapply sign, add start
  assign rnd     = prod_r + HALF;
  assign mag_s   = {1'b0, rnd[SP_W-1:FRAC_W]};
  assign off     = neg_r ? -mag_s : mag_s;
  assign sum     = OFF_W'(start_r) + off;
  assign coord_o = sum[COORD_W-1:0];
  assign tag_o   = tag_r;

endmodule

### rtl/core/segment_hyperplane_intersection.sv
// Channel   Handshake          Ports
// -------   ----------------   --------------------------------------------------
// input     start & !busy      in_a_coord in_b_coord in_normal_coord in_point_coord
//                              in_last_element
// result    out_strobe         out_coord out_hit out_dim_error out_last_result
// config    cfg_we             cfg_wdata (parallel_tolerance)
//
// A coordinate word: products are registered at accept, accumulated the next cycle.
// After the last word, S_MAG forms sign and magnitude and S_TEST runs the range
// test; a miss or dim error word is registered out of S_TEST and then strobes.
// On a hit the restoring divider sets the pace, then one coordinate per cycle
// streams out of the a/d RAM through the scale stage to the result register;
// busy drops once the read and scale tags have drained.
// rst_n is synchronous; the a/d RAM needs no clearing, only entries of the
// current vector are read. Results cannot be stalled by the receiver.
`include "segment_hyperplane_intersection_assert.svh"

module segment_hyperplane_intersection import shi_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] in_a_coord,
  input  logic signed [COORD_W-1:0] in_b_coord,
  input  logic signed [COORD_W-1:0] in_normal_coord,
  input  logic signed [COORD_W-1:0] in_point_coord,
  input  logic                      in_last_element,
  output logic                      out_strobe,
  output logic signed [COORD_W-1:0] out_coord,
  output logic                      out_hit,
  output logic                      out_dim_error,
  output logic                      out_last_result,
  input  logic                      cfg_we,
  input  logic [TOL_W-1:0]          cfg_wdata
);

  localparam int CNT_W  = $clog2(MAX_DIM + 1);
  localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int RAM_W  = COORD_W + DIR_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIM);

  // FSM
  shi_state_t state_r, state_nxt;

  // control from the output decode
  logic accept;
  logic item_ok;
  logic miss;
  logic ram_we;
  logic ram_re;
  logic rd_last;
  logic div_start;
  logic single;
  logic clear;

  // config
  logic [TOL_W-1:0] tol_r;

  // accumulation state
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     ovf_r, ovf_nxt;
  logic signed [SUM_W-1:0]  num_r, num_nxt;
  logic signed [SUM_W-1:0]  den_r, den_nxt;
  logic signed [PROD_W-1:0] pnum_r, pden_r;
  logic                     item_ok_r;
  logic                     last_r;

  // differences of the incoming word
  logic signed [DIR_W-1:0]  diff_pa;
  logic signed [DIR_W-1:0]  diff_ba;

  // range test operands
  logic [SUM_W-1:0] un_r, ud_r;
  logic             num_neg_r, den_neg_r, num_nz_r;

  // emit side
  logic [CNT_W-1:0]          k_r, k_nxt;
  shi_tag_t                  rd_tag_r, rd_tag_nxt;
  shi_tag_t                  sc_tag;
  logic signed [COORD_W-1:0] sc_coord;
  logic [RAM_W-1:0]          ram_rdata;
  logic                      div_done;
  logic [ALPHA_W-1:0]        alpha;

  // result word register
  logic                      out_strobe_r, out_strobe_nxt;
  logic signed [COORD_W-1:0] out_coord_r, out_coord_nxt;
  logic                      out_hit_r, out_hit_nxt;
  logic                      out_err_r, out_err_nxt;
  logic                      out_last_r, out_last_nxt;

  assign diff_pa = DIR_W'(in_point_coord) - DIR_W'(in_a_coord);
  assign diff_ba = DIR_W'(in_b_coord) - DIR_W'(in_a_coord);

  // ---------------------------------------------------------------------------
  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_ACC;
      end
      S_ACC: begin
        state_nxt = last_r ? S_MAG : S_IDLE;
      end
      S_MAG: begin
        state_nxt = S_TEST;
      end
      S_TEST: begin
        state_nxt = single ? S_IDLE : S_DIV;
      end
      S_DIV: begin
        if (div_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (rd_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!rd_tag_r.valid && !sc_tag.valid) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // FSM outputs
  always_comb begin
    busy      = (state_r != S_IDLE);
    accept    = start && !busy;
    item_ok   = cnt_r < MAX_CNT;
    // parallel, alpha < 0, or alpha > 1
    miss      = (ud_r <= SUM_W'(tol_r)) ||
                (num_nz_r && (num_neg_r != den_neg_r)) ||
                (un_r > ud_r);
    ram_we    = accept && item_ok;
    ram_re    = (state_r == S_EMIT);
    rd_last   = (k_r + CNT_W'(1)) == cnt_r;
    single    = (state_r == S_TEST) && (ovf_r || miss);
    div_start = (state_r == S_TEST) && !ovf_r && !miss;
    clear     = single || (ram_re && rd_last);
  end

  // ---------------------------------------------------------------------------
  // datapath next values
  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    num_nxt = num_r;
    den_nxt = den_r;
    if (clear) begin
      cnt_nxt = '0;
      ovf_nxt = 1'b0;
      num_nxt = '0;
      den_nxt = '0;
    end else begin
      if (accept && item_ok) cnt_nxt = cnt_r + CNT_W'(1);
      if (accept && !item_ok) ovf_nxt = 1'b1;
      if ((state_r == S_ACC) && item_ok_r) begin
        num_nxt = num_r + SUM_W'(pnum_r);
        den_nxt = den_r + SUM_W'(pden_r);
      end
    end

    k_nxt = k_r;
    if (div_start) begin
      k_nxt = '0;
    end else if (ram_re) begin
      k_nxt = k_r + CNT_W'(1);
    end

    rd_tag_nxt.valid = ram_re;
    rd_tag_nxt.last  = rd_last;

    // one result word: miss/error from the test, or a scaled coordinate
    out_strobe_nxt = single || sc_tag.valid;
    out_coord_nxt  = single ? '0 : sc_coord;
    out_hit_nxt    = !single;
    out_err_nxt    = single && ovf_r;
    out_last_nxt   = single || sc_tag.last;
  end

  // ---------------------------------------------------------------------------
  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      tol_r        <= '0;
      cnt_r        <= '0;
      ovf_r        <= 1'b0;
      num_r        <= '0;
      den_r        <= '0;
      rd_tag_r     <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_we) tol_r <= cfg_wdata;
      cnt_r        <= cnt_nxt;
      ovf_r        <= ovf_nxt;
      num_r        <= num_nxt;
      den_r        <= den_nxt;
      rd_tag_r     <= rd_tag_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      pnum_r    <= PROD_W'(in_normal_coord) * PROD_W'(diff_pa);
      pden_r    <= PROD_W'(in_normal_coord) * PROD_W'(diff_ba);
      item_ok_r <= item_ok;
      last_r    <= in_last_element;
    end
    if (state_r == S_MAG) begin
      un_r      <= num_r[SUM_W-1] ? SUM_W'(-num_r) : SUM_W'(num_r);
      ud_r      <= den_r[SUM_W-1] ? SUM_W'(-den_r) : SUM_W'(den_r);
      num_neg_r <= num_r[SUM_W-1];
      den_neg_r <= den_r[SUM_W-1];
      num_nz_r  <= |num_r;
    end
    k_r         <= k_nxt;
    out_coord_r <= out_coord_nxt;
    out_hit_r   <= out_hit_nxt;
    out_err_r   <= out_err_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_strobe      = out_strobe_r;
  assign out_coord       = out_coord_r;
  assign out_hit         = out_hit_r;
  assign out_dim_error   = out_err_r;
  assign out_last_result = out_last_r;

  // ---------------------------------------------------------------------------
  // a / (b - a) store, one word per coordinate
  shi_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_DIM)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata ({in_a_coord, diff_ba}),
    .re    (ram_re),
    .raddr (k_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // alpha = floor(|num| * 2^16 / |den|)
  shi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (un_r),
    .den   (ud_r),
    .done  (div_done),
    .quot  (alpha)
  );

  // a + round(alpha * d)
  shi_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .alpha_i (alpha),
    .tag_i   (rd_tag_r),
    .start_i (ram_rdata[RAM_W-1 -: COORD_W]),
    .dir_i   (ram_rdata[DIR_W-1:0]),
    .tag_o   (sc_tag),
    .coord_o (sc_coord)
  );

  // ---------------------------------------------------------------------------
  // checks
  `SHI_ASSERT_SAME(a_strobe_after_busy, clk, rst_n, out_strobe, $past(busy), "result word without prior busy")
  `SHI_ASSERT_SAME(a_err_word_shape, clk, rst_n, out_strobe && out_dim_error, !out_hit && out_last_result && (out_coord == '0), "malformed dim error word")
  `SHI_ASSERT_SAME(a_ram_in_range, clk, rst_n, ram_we, cnt_r < MAX_CNT, "store write past MAX_DIM")
  `SHI_ASSERT_SAME(a_div_done_in_div, clk, rst_n, div_done, state_r == S_DIV, "divider done outside divide state")
  `SHI_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "no busy after accepted word")

endmodule
